/* hdl/hvd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// hvd_pkg
// Shared constants, types and arithmetic helpers for the haversine distance
// datapath. All angles and trigonometric values are Q32 fixed point.
// -----------------------------------------------------------------------------
package hvd_pkg;

  localparam int unsigned TERMS      = 10;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned ASIN_STEPS = 33;

  localparam logic [33:0] PIQ      = 34'd13493037705;
  localparam logic [32:0] HPIQ     = 33'd6746518852;
  localparam logic [30:0] KQ       = 31'd2012227593;
  localparam logic [32:0] R_MM     = 33'd6378137000;
  localparam logic [34:0] DIST_MAX = 35'd20040000000;
  localparam logic [32:0] ONEQ     = 33'h1_0000_0000;

  localparam int unsigned RECIP_SHIFT = 45;
  localparam logic [63:0] RECIP_1  = ((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6;
  localparam logic [63:0] RECIP_2  = ((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20;
  localparam logic [63:0] RECIP_3  = ((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42;
  localparam logic [63:0] RECIP_4  = ((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72;
  localparam logic [63:0] RECIP_5  = ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110;
  localparam logic [63:0] RECIP_6  = ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156;
  localparam logic [63:0] RECIP_7  = ((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210;
  localparam logic [63:0] RECIP_8  = ((64'd1 << RECIP_SHIFT) + 64'd271) / 64'd272;
  localparam logic [63:0] RECIP_9  = ((64'd1 << RECIP_SHIFT) + 64'd341) / 64'd342;
  localparam logic [63:0] RECIP_10 = ((64'd1 << RECIP_SHIFT) + 64'd419) / 64'd420;

  typedef struct packed {
    logic        ok;
    logic [32:0] cand;
    logic [31:0] y;
    logic        flip;
  } asin_tag_t;

  localparam int unsigned TAG_W = $bits(asin_tag_t);

  // Q32 product with rounding: floor((a * b + 2^31) / 2^32).
  function automatic logic [37:0] mulq(input logic [34:0] a, input logic [34:0] b);
    logic [69:0] p;
    p = 70'(a) * 70'(b) + 70'h8000_0000;
    return p[69:32];
  endfunction

  // Reciprocal of (2k)(2k+1) scaled by 2^45, rounded up.
  function automatic logic [42:0] recip(input logic [3:0] k);
    logic [63:0] r;
    case (k)
      4'd1:    r = RECIP_1;
      4'd2:    r = RECIP_2;
      4'd3:    r = RECIP_3;
      4'd4:    r = RECIP_4;
      4'd5:    r = RECIP_5;
      4'd6:    r = RECIP_6;
      4'd7:    r = RECIP_7;
      4'd8:    r = RECIP_8;
      4'd9:    r = RECIP_9;
      4'd10:   r = RECIP_10;
      default: r = RECIP_1;
    endcase
    return r[42:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/hvd_sin_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// hvd_sin_cell
// One Taylor term of the sine series: multiplies the previous term by x^2,
// divides by the term's constant and adds or subtracts it from the sum.
// -----------------------------------------------------------------------------
module hvd_sin_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [3:0]                k_i,
  input  logic                      valid_i,
  input  logic [33:0]               x2_i,
  input  logic [32:0]               term_i,
  input  logic signed [35:0]        sum_i,
  input  logic [hvd_pkg::TAG_W-1:0] tag_i,
  output logic                      valid_o,
  output logic [33:0]               x2_o,
  output logic [32:0]               term_o,
  output logic signed [35:0]        sum_o,
  output logic [hvd_pkg::TAG_W-1:0] tag_o
);

  logic                      a_valid_q;
  logic [33:0]               a_x2_q;
  logic [35:0]               a_p_q;
  logic [35:0]               a_p_d;
  logic signed [35:0]        a_sum_q;
  logic [hvd_pkg::TAG_W-1:0] a_tag_q;
  logic [37:0]               prod;
  logic [78:0]               qprod;
  logic [32:0]               q;
  logic signed [35:0]        sum_d;

  assign prod  = hvd_pkg::mulq(35'(term_i), 35'(x2_i));
  assign a_p_d = prod[35:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_x2_q  <= x2_i;
      a_p_q   <= a_p_d;
      a_sum_q <= sum_i;
      a_tag_q <= tag_i;
    end
  end

  assign qprod = 79'(a_p_q) * 79'(hvd_pkg::recip(k_i));
  assign q     = qprod[77:45];

  always_comb begin
    if (k_i[0]) begin
      sum_d = a_sum_q - $signed({3'b000, q});
    end else begin
      sum_d = a_sum_q + $signed({3'b000, q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_o   <= a_x2_q;
      term_o <= q;
      sum_o  <= sum_d;
      tag_o  <= a_tag_q;
    end
  end

endmodule
`default_nettype wire

/* hdl/hvd_sin.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// hvd_sin
// Pipelined Q32 sine for arguments in [0, pi/2]: a squaring stage, a row of
// ten series cells and a clamping stage. A tag travels with each argument.
// -----------------------------------------------------------------------------
module hvd_sin (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [32:0]               x_i,
  input  logic [hvd_pkg::TAG_W-1:0] tag_i,
  output logic                      valid_o,
  output logic [32:0]               sin_o,
  output logic [hvd_pkg::TAG_W-1:0] tag_o
);

  logic                      s0_valid_q;
  logic [33:0]               s0_x2_q;
  logic [32:0]               s0_x_q;
  logic [hvd_pkg::TAG_W-1:0] s0_tag_q;
  logic [37:0]               sq;

  logic                      c_valid [hvd_pkg::TERMS+1];
  logic [33:0]               c_x2    [hvd_pkg::TERMS+1];
  logic [32:0]               c_term  [hvd_pkg::TERMS+1];
  logic signed [35:0]        c_sum   [hvd_pkg::TERMS+1];
  logic [hvd_pkg::TAG_W-1:0] c_tag   [hvd_pkg::TERMS+1];
  logic signed [35:0]        last_sum;
  logic [32:0]               sin_d;

  assign sq = hvd_pkg::mulq(35'(x_i), 35'(x_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en_i) begin
      s0_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_x2_q  <= sq[33:0];
      s0_x_q   <= x_i;
      s0_tag_q <= tag_i;
    end
  end

  assign c_valid[0] = s0_valid_q;
  assign c_x2[0]    = s0_x2_q;
  assign c_term[0]  = s0_x_q;
  assign c_sum[0]   = $signed({3'b000, s0_x_q});
  assign c_tag[0]   = s0_tag_q;

  for (genvar g = 0; g < hvd_pkg::TERMS; g++) begin : g_term
    hvd_sin_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .k_i     (4'(g + 1)),
      .valid_i (c_valid[g]),
      .x2_i    (c_x2[g]),
      .term_i  (c_term[g]),
      .sum_i   (c_sum[g]),
      .tag_i   (c_tag[g]),
      .valid_o (c_valid[g+1]),
      .x2_o    (c_x2[g+1]),
      .term_o  (c_term[g+1]),
      .sum_o   (c_sum[g+1]),
      .tag_o   (c_tag[g+1])
    );
  end

  assign last_sum = c_sum[hvd_pkg::TERMS];

  always_comb begin
    if (last_sum < 36'sd0) begin
      sin_d = 33'd0;
    end else if (last_sum > 36'sd4294967296) begin
      sin_d = hvd_pkg::ONEQ;
    end else begin
      sin_d = last_sum[32:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= c_valid[hvd_pkg::TERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= sin_d;
      tag_o <= c_tag[hvd_pkg::TERMS];
    end
  end

endmodule
`default_nettype wire

/* hdl/hvd_sqrt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// hvd_sqrt_cell
// One digit step of the integer square root of v * 2^32: brings down two
// bits of the radicand and decides one bit of the root.
// -----------------------------------------------------------------------------
module hvd_sqrt_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [4:0]  idx_i,
  input  logic        valid_i,
  input  logic [31:0] v_i,
  input  logic [33:0] rem_i,
  input  logic [31:0] root_i,
  input  logic        flip_i,
  output logic        valid_o,
  output logic [31:0] v_o,
  output logic [33:0] rem_o,
  output logic [31:0] root_o,
  output logic        flip_o
);

  logic [1:0]  pair;
  logic [35:0] trial;
  logic [35:0] t;
  logic [35:0] diff;
  logic        ge;

  assign pair  = idx_i[4] ? v_i[{idx_i[3:0], 1'b0} +: 2] : 2'b00;
  assign trial = {rem_i, pair};
  assign t     = {2'b00, root_i, 2'b01};
  assign diff  = trial - t;
  assign ge    = (trial >= t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_o    <= v_i;
      rem_o  <= ge ? diff[33:0] : trial[33:0];
      root_o <= {root_i[30:0], ge};
      flip_o <= flip_i;
    end
  end

endmodule
`default_nettype wire

/* hdl/hvd_asin_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// hvd_asin_cell
// One bit of the arcsine search: tries the candidate with this bit set,
// evaluates its sine and keeps the bit when the sine stays within the target.
// -----------------------------------------------------------------------------
module hvd_asin_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [5:0]  bit_i,
  input  logic        valid_i,
  input  logic [32:0] th_i,
  input  logic [31:0] y_i,
  input  logic        flip_i,
  output logic        valid_o,
  output logic [32:0] th_o,
  output logic [31:0] y_o,
  output logic        flip_o
);

  logic [32:0]               mask;
  hvd_pkg::asin_tag_t        tag_in;
  hvd_pkg::asin_tag_t        tag_out;
  logic [hvd_pkg::TAG_W-1:0] tag_bits;
  logic                      s_valid;
  logic [32:0]               s_val;
  logic                      take;

  assign mask         = 33'd1 << bit_i;
  assign tag_in.cand  = th_i | mask;
  assign tag_in.ok    = ((th_i | mask) <= hvd_pkg::HPIQ);
  assign tag_in.y     = y_i;
  assign tag_in.flip  = flip_i;

  hvd_sin u_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_i),
    .x_i     (tag_in.cand),
    .tag_i   (tag_in),
    .valid_o (s_valid),
    .sin_o   (s_val),
    .tag_o   (tag_bits)
  );

  assign tag_out = hvd_pkg::asin_tag_t'(tag_bits);
  assign take    = tag_out.ok && (s_val <= {1'b0, tag_out.y});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= s_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      th_o   <= take ? tag_out.cand : (tag_out.cand & ~mask);
      y_o    <= tag_out.y;
      flip_o <= tag_out.flip;
    end
  end

endmodule
`default_nettype wire

/* hdl/haversine_distance_arrival.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one position pair per cycle unless the skid register is full; the
// whole path is a row of pipelined cells, its longest part the 33 arcsine cells.
// Reset clears all valid flags and sets the arrival radius to zero.
// -----------------------------------------------------------------------------
// haversine_distance_arrival
// Great-circle distance between two positions by the haversine formula, with
// a flag for distances below the configured arrival radius.
// -----------------------------------------------------------------------------
module haversine_distance_arrival (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [34:0] arrival_radius_mm_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [30:0] lat_a_i,
  input  logic [31:0] lng_a_i,
  input  logic [30:0] lat_b_i,
  input  logic [31:0] lng_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [34:0] distance_mm_o,
  output logic        arrived_o
);

  logic        en;
  logic [34:0] radius_q;

  // Front: differences, magnitudes and conversion to radians.
  logic [31:0] dlat;
  logic [32:0] dlng;
  logic        f1_valid_q;
  logic [31:0] f1_mdlat_q;
  logic [32:0] f1_mdlng_q;
  logic [30:0] f1_mla_q;
  logic [30:0] f1_mlb_q;

  logic [63:0] p_dlat;
  logic [63:0] p_dlng;
  logic [63:0] p_la;
  logic [63:0] p_lb;
  logic        f2_valid_q;
  logic [34:0] f2_rdlat_q;
  logic [34:0] f2_rdlng_q;
  logic [34:0] f2_rla_q;
  logic [34:0] f2_rlb_q;

  logic [34:0] r1_lat;
  logic [34:0] r2_lat;
  logic [34:0] r1_lng;
  logic [34:0] r2_lng;
  logic [34:0] xc1;
  logic [34:0] xc2;
  logic        neg1;
  logic        neg2;
  logic [34:0] ca1;
  logic [34:0] ca2;
  logic        f3_valid_q;
  logic [32:0] f3_s1_q;
  logic [32:0] f3_s2_q;
  logic [32:0] f3_c1_q;
  logic [32:0] f3_c2_q;
  logic        f3_neg1_q;
  logic        f3_neg2_q;

  logic                      sn_valid;
  logic [32:0]               sn_s1;
  logic [32:0]               sn_s2;
  logic [32:0]               sn_c1;
  logic [32:0]               sn_c2;
  logic [hvd_pkg::TAG_W-1:0] sn_tag;

  logic [37:0] m_s1;
  logic [37:0] m_s2;
  logic [37:0] m_c;
  logic        t1_valid_q;
  logic [32:0] t1_s1_q;
  logic [32:0] t1_s2_q;
  logic [32:0] t1_mc_q;
  logic        t1_sgn_q;

  logic [37:0] m_h;
  logic        t2_valid_q;
  logic [32:0] t2_s1_q;
  logic [32:0] t2_m_q;
  logic        t2_sgn_q;

  logic signed [35:0] h;
  logic [32:0]        hu;
  logic               flip;
  logic [32:0]        vw;
  logic               t3_valid_q;
  logic [31:0]        t3_v_q;
  logic               t3_flip_q;

  logic        q_valid [hvd_pkg::SQRT_STEPS+1];
  logic [31:0] q_v     [hvd_pkg::SQRT_STEPS+1];
  logic [33:0] q_rem   [hvd_pkg::SQRT_STEPS+1];
  logic [31:0] q_root  [hvd_pkg::SQRT_STEPS+1];
  logic        q_flip  [hvd_pkg::SQRT_STEPS+1];

  logic        a_valid [hvd_pkg::ASIN_STEPS+1];
  logic [32:0] a_th    [hvd_pkg::ASIN_STEPS+1];
  logic [31:0] a_y     [hvd_pkg::ASIN_STEPS+1];
  logic        a_flip  [hvd_pkg::ASIN_STEPS+1];

  logic [32:0] theta;
  logic [37:0] dprod;
  logic        d1_valid_q;
  logic [35:0] d1_dist_q;

  logic [34:0] sat;
  logic        p_valid_q;
  logic [34:0] p_dist_q;
  logic        p_arr_q;

  logic        out_valid_q;
  logic        skid_valid_q;
  logic [34:0] skid_dist_q;
  logic        skid_arr_q;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 35'd0;
    end else if (cfg_valid_i) begin
      radius_q <= arrival_radius_mm_i;
    end
  end

  // The whole pipeline advances while the skid register is empty.
  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  assign dlat = {lat_a_i[30], lat_a_i} - {lat_b_i[30], lat_b_i};
  assign dlng = {lng_a_i[31], lng_a_i} - {lng_b_i[31], lng_b_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
      f3_valid_q <= 1'b0;
      t1_valid_q <= 1'b0;
      t2_valid_q <= 1'b0;
      t3_valid_q <= 1'b0;
      d1_valid_q <= 1'b0;
      p_valid_q  <= 1'b0;
    end else if (en) begin
      f1_valid_q <= in_valid_i;
      f2_valid_q <= f1_valid_q;
      f3_valid_q <= f2_valid_q;
      t1_valid_q <= sn_valid;
      t2_valid_q <= t1_valid_q;
      t3_valid_q <= t2_valid_q;
      d1_valid_q <= a_valid[hvd_pkg::ASIN_STEPS];
      p_valid_q  <= d1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_mdlat_q <= dlat[31] ? (32'd0 - dlat) : dlat;
      f1_mdlng_q <= dlng[32] ? (33'd0 - dlng) : dlng;
      f1_mla_q   <= lat_a_i[30] ? (31'd0 - lat_a_i) : lat_a_i;
      f1_mlb_q   <= lat_b_i[30] ? (31'd0 - lat_b_i) : lat_b_i;
    end
  end

  assign p_dlat = 64'(f1_mdlat_q) * 64'(hvd_pkg::KQ) + (64'd1 << 28);
  assign p_dlng = 64'(f1_mdlng_q) * 64'(hvd_pkg::KQ) + (64'd1 << 28);
  assign p_la   = 64'(f1_mla_q) * 64'(hvd_pkg::KQ) + (64'd1 << 27);
  assign p_lb   = 64'(f1_mlb_q) * 64'(hvd_pkg::KQ) + (64'd1 << 27);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_rdlat_q <= p_dlat[63:29];
      f2_rdlng_q <= p_dlng[63:29];
      f2_rla_q   <= p_la[62:28];
      f2_rlb_q   <= p_lb[62:28];
    end
  end

  // Range reduction for sin^2 and the cosine arguments.
  always_comb begin
    r1_lat = (f2_rdlat_q >= 35'(hvd_pkg::PIQ)) ? f2_rdlat_q - 35'(hvd_pkg::PIQ) : f2_rdlat_q;
    r2_lat = (r1_lat > 35'(hvd_pkg::HPIQ)) ? 35'(hvd_pkg::PIQ) - r1_lat : r1_lat;
    r1_lng = (f2_rdlng_q >= 35'(hvd_pkg::PIQ)) ? f2_rdlng_q - 35'(hvd_pkg::PIQ) : f2_rdlng_q;
    r2_lng = (r1_lng > 35'(hvd_pkg::HPIQ)) ? 35'(hvd_pkg::PIQ) - r1_lng : r1_lng;
    xc1    = (f2_rla_q > 35'(hvd_pkg::PIQ)) ? 35'(hvd_pkg::PIQ) : f2_rla_q;
    xc2    = (f2_rlb_q > 35'(hvd_pkg::PIQ)) ? 35'(hvd_pkg::PIQ) : f2_rlb_q;
    neg1   = (xc1 > 35'(hvd_pkg::HPIQ));
    neg2   = (xc2 > 35'(hvd_pkg::HPIQ));
    ca1    = neg1 ? xc1 - 35'(hvd_pkg::HPIQ) : 35'(hvd_pkg::HPIQ) - xc1;
    ca2    = neg2 ? xc2 - 35'(hvd_pkg::HPIQ) : 35'(hvd_pkg::HPIQ) - xc2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f3_s1_q   <= r2_lat[32:0];
      f3_s2_q   <= r2_lng[32:0];
      f3_c1_q   <= ca1[32:0];
      f3_c2_q   <= ca2[32:0];
      f3_neg1_q <= neg1;
      f3_neg2_q <= neg2;
    end
  end

  hvd_sin u_sin_dlat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f3_valid_q),
    .x_i     (f3_s1_q),
    .tag_i   ({(hvd_pkg::TAG_W - 2)'(0), f3_neg1_q, f3_neg2_q}),
    .valid_o (sn_valid),
    .sin_o   (sn_s1),
    .tag_o   (sn_tag)
  );

  hvd_sin u_sin_dlng (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f3_valid_q),
    .x_i     (f3_s2_q),
    .tag_i   ('0),
    .valid_o (),
    .sin_o   (sn_s2),
    .tag_o   ()
  );

  hvd_sin u_cos_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f3_valid_q),
    .x_i     (f3_c1_q),
    .tag_i   ('0),
    .valid_o (),
    .sin_o   (sn_c1),
    .tag_o   ()
  );

  hvd_sin u_cos_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f3_valid_q),
    .x_i     (f3_c2_q),
    .tag_i   ('0),
    .valid_o (),
    .sin_o   (sn_c2),
    .tag_o   ()
  );

  // Combination of the haversine terms.
  assign m_s1 = hvd_pkg::mulq(35'(sn_s1), 35'(sn_s1));
  assign m_s2 = hvd_pkg::mulq(35'(sn_s2), 35'(sn_s2));
  assign m_c  = hvd_pkg::mulq(35'(sn_c1), 35'(sn_c2));

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_s1_q  <= m_s1[32:0];
      t1_s2_q  <= m_s2[32:0];
      t1_mc_q  <= m_c[32:0];
      t1_sgn_q <= (sn_tag[1] && (sn_c1 != 33'd0)) != (sn_tag[0] && (sn_c2 != 33'd0));
    end
  end

  assign m_h = hvd_pkg::mulq(35'(t1_mc_q), 35'(t1_s2_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      t2_s1_q  <= t1_s1_q;
      t2_m_q   <= m_h[32:0];
      t2_sgn_q <= t1_sgn_q;
    end
  end

  always_comb begin
    if (t2_sgn_q) begin
      h = $signed({3'b000, t2_s1_q}) - $signed({3'b000, t2_m_q});
    end else begin
      h = $signed({3'b000, t2_s1_q}) + $signed({3'b000, t2_m_q});
    end
    if (h < 36'sd0) begin
      hu = 33'd0;
    end else if (h > 36'sd4294967296) begin
      hu = hvd_pkg::ONEQ;
    end else begin
      hu = h[32:0];
    end
    flip = (hu > 33'h0_8000_0000);
    vw   = flip ? hvd_pkg::ONEQ - hu : hu;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t3_v_q    <= vw[31:0];
      t3_flip_q <= flip;
    end
  end

  // Square root, one root bit per cell.
  assign q_valid[0] = t3_valid_q;
  assign q_v[0]     = t3_v_q;
  assign q_rem[0]   = 34'd0;
  assign q_root[0]  = 32'd0;
  assign q_flip[0]  = t3_flip_q;

  for (genvar g = 0; g < hvd_pkg::SQRT_STEPS; g++) begin : g_sqrt
    hvd_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (5'(hvd_pkg::SQRT_STEPS - 1 - g)),
      .valid_i (q_valid[g]),
      .v_i     (q_v[g]),
      .rem_i   (q_rem[g]),
      .root_i  (q_root[g]),
      .flip_i  (q_flip[g]),
      .valid_o (q_valid[g+1]),
      .v_o     (q_v[g+1]),
      .rem_o   (q_rem[g+1]),
      .root_o  (q_root[g+1]),
      .flip_o  (q_flip[g+1])
    );
  end

  // Arcsine, one angle bit per cell.
  assign a_valid[0] = q_valid[hvd_pkg::SQRT_STEPS];
  assign a_th[0]    = 33'd0;
  assign a_y[0]     = q_root[hvd_pkg::SQRT_STEPS];
  assign a_flip[0]  = q_flip[hvd_pkg::SQRT_STEPS];

  for (genvar g = 0; g < hvd_pkg::ASIN_STEPS; g++) begin : g_asin
    hvd_asin_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .bit_i   (6'(hvd_pkg::ASIN_STEPS - 1 - g)),
      .valid_i (a_valid[g]),
      .th_i    (a_th[g]),
      .y_i     (a_y[g]),
      .flip_i  (a_flip[g]),
      .valid_o (a_valid[g+1]),
      .th_o    (a_th[g+1]),
      .y_o     (a_y[g+1]),
      .flip_o  (a_flip[g+1])
    );
  end

  assign theta = a_flip[hvd_pkg::ASIN_STEPS] ? hvd_pkg::HPIQ - a_th[hvd_pkg::ASIN_STEPS]
                                             : a_th[hvd_pkg::ASIN_STEPS];
  assign dprod = hvd_pkg::mulq({1'b0, theta, 1'b0}, 35'(hvd_pkg::R_MM));

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_dist_q <= dprod[35:0];
    end
  end

  assign sat = (d1_dist_q > 36'(hvd_pkg::DIST_MAX)) ? hvd_pkg::DIST_MAX : d1_dist_q[34:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_dist_q <= sat;
      p_arr_q  <= (sat < radius_q);
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= p_valid_q;
      end
    end else if (p_valid_q && en) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        distance_mm_o <= skid_dist_q;
        arrived_o     <= skid_arr_q;
      end else begin
        distance_mm_o <= p_dist_q;
        arrived_o     <= p_arr_q;
      end
    end else if (p_valid_q && en) begin
      skid_dist_q <= p_dist_q;
      skid_arr_q  <= p_arr_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
